/* src/fhrl_pkg.sv */
// ----------------------------------------------------------------------------
// fhrl_pkg: fault history ring log shared definitions
// Command codes, the input and result word layouts and the control word
// passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package fhrl_pkg;

	localparam logic [1:0] CMD_LOG   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] fault_code;
		logic [7:0] fault_arg;
		logic [7:0] read_index;
	} in_word_t;

	typedef struct packed {
		logic [7:0] entry_code;
		logic [7:0] entry_arg;
		logic       entry_valid;
		logic [3:0] entry_count;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // input word accepted this cycle
	} fhrl_ctrl_t;

endpackage

/* src/fhrl_ctrl.sv */
// ----------------------------------------------------------------------------
// fhrl_ctrl: handshake controller
// Tracks whether a result word is held; tells the datapath when to take an
// input word.
// ----------------------------------------------------------------------------
module fhrl_ctrl import fhrl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output fhrl_ctrl_t ctrl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_HOLD = 1'b1;

	logic state_q;
	logic state_d;

	// a held result leaving this cycle frees the register for the next word
	assign in_ready  = (state_q == ST_IDLE) || out_ready;
	assign out_valid = (state_q == ST_HOLD);
	assign ctrl.load = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.load) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (ctrl.load) begin
					state_d = ST_HOLD;
				end else if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/fhrl_dp.sv */
// ----------------------------------------------------------------------------
// fhrl_dp: fault history ring log datapath
// Entry memory, oldest pointer, fill count and the registered result.
// ----------------------------------------------------------------------------
module fhrl_dp import fhrl_pkg::*; #(
	parameter int LOG_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  fhrl_ctrl_t ctrl,
	input  in_word_t   in_data,
	output out_word_t  out_data
);

	localparam int PW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CW = $clog2(LOG_DEPTH + 1);
	localparam int SW = CW + 1;

	logic [15:0]   mem [LOG_DEPTH];
	logic [15:0]   rd_q;
	logic [PW-1:0] oldest_q;
	logic [CW-1:0] fill_q;
	logic          hit_q;

	logic          full;
	logic          hit;
	logic [SW-1:0] wr_sum;
	logic [SW-1:0] wr_red;
	logic [SW-1:0] rd_sum;
	logic [SW-1:0] rd_red;
	logic [PW-1:0] wr_slot;
	logic [PW-1:0] rd_slot;
	logic [PW-1:0] oldest_inc;

	assign full = (fill_q == CW'(LOG_DEPTH));
	assign hit  = (in_data.cmd == CMD_READ) && (8'(fill_q) > in_data.read_index);

	// sums for writes and in-range reads stay below twice the depth, so one subtract wraps them;
	// when full, oldest + depth wraps back onto the oldest slot
	assign wr_sum  = SW'(oldest_q) + SW'(fill_q);
	assign wr_red  = (wr_sum >= SW'(LOG_DEPTH)) ? (wr_sum - SW'(LOG_DEPTH)) : wr_sum;
	assign wr_slot = wr_red[PW-1:0];

	// index only matters when below the count, so its low bits suffice
	assign rd_sum  = SW'(oldest_q) + SW'(in_data.read_index[CW-1:0]);
	assign rd_red  = (rd_sum >= SW'(LOG_DEPTH)) ? (rd_sum - SW'(LOG_DEPTH)) : rd_sum;
	assign rd_slot = rd_red[PW-1:0];

	assign oldest_inc = (oldest_q == PW'(LOG_DEPTH - 1)) ? '0 : oldest_q + PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q   <= '0;
			hit_q    <= 1'b0;
		end else if (ctrl.load) begin
			hit_q <= hit;
			if (in_data.cmd == CMD_LOG) begin
				if (full) begin
					oldest_q <= oldest_inc;
				end else begin
					fill_q <= fill_q + CW'(1);
				end
			end else if (in_data.cmd == CMD_CLEAR) begin
				oldest_q <= '0;
				fill_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && (in_data.cmd == CMD_LOG)) begin
			mem[wr_slot] <= {in_data.fault_code, in_data.fault_arg};
		end
		if (ctrl.load && (in_data.cmd == CMD_READ)) begin
			rd_q <= mem[rd_slot];
		end
	end

	assign out_data.entry_code  = hit_q ? rd_q[15:8] : 8'd0;
	assign out_data.entry_arg   = hit_q ? rd_q[7:0] : 8'd0;
	assign out_data.entry_valid = hit_q;
	assign out_data.entry_count = 4'(fill_q);

endmodule

/* src/fault_history_ring_log.sv */
// ----------------------------------------------------------------------------
// fault_history_ring_log: circular overwrite fault history
// Top level: handshake controller plus entry memory datapath.
// ----------------------------------------------------------------------------
// Keeps the last LOG_DEPTH fault code/argument pairs in a ring. A log word
// appends a pair, overwriting the oldest once full; a read word returns the
// entry at read_index counted from the oldest, with entry_valid set when the
// index is below the count (code, argument and valid are zero otherwise, and
// for log, clear and the unused command code, which changes nothing). A clear
// word empties the log. Each input word yields exactly one result word in the
// cycle after it is accepted, and every result carries the count after the
// operation (masked to four bits). The single result register is the only
// stage; a new input word is taken in the same cycle the held result leaves,
// so the block sustains one word per cycle while the sink keeps out_ready
// high. The result comes from the registered read port of the entry
// memory. There is no clearing pass after reset: entries never written are
// unreachable because reads are bounded by the fill count.
// ----------------------------------------------------------------------------
module fault_history_ring_log import fhrl_pkg::*; #(
	parameter int LOG_DEPTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	fhrl_ctrl_t ctrl;

	// handshake: holds or frees the result register
	fhrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctrl      (ctrl)
	);

	// ring storage, pointers and result register
	fhrl_dp #(
		.LOG_DEPTH (LOG_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.in_data  (in_data),
		.out_data (out_data)
	);

`ifndef ASSERT_OFF
	// a clear always reports an empty log
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_data.cmd == CMD_CLEAR)) |=>
		(out_valid && (out_data.entry_count == 4'd0)))
		else $error("clear did not report an empty log");

	// a log leaves at least one entry (count not aliased by the 4-bit mask)
	a_log_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		((LOG_DEPTH < 16) && in_valid && in_ready && (in_data.cmd == CMD_LOG)) |=>
		(out_data.entry_count != 4'd0))
		else $error("log reported an empty log");

	// only a read may return a valid entry
	a_valid_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_data.cmd != CMD_READ)) |=>
		!out_data.entry_valid)
		else $error("valid entry on a non-read command");

	// an invalid result carries code none and argument zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.entry_valid) |->
		((out_data.entry_code == 8'd0) && (out_data.entry_arg == 8'd0)))
		else $error("invalid result with nonzero payload");
`endif

endmodule

/* sim/tb_fault_history_ring_log.sv */
// ----------------------------------------------------------------------------
// tb_fault_history_ring_log: self-checking bench for the fault history ring
// Drives log, read, clear and unused command words through the valid/ready
// input and tracks the ring contents, oldest slot and fill count on the side.
// Every result word is compared field by field with the predicted one, in
// order, under random idling on both sides.
// ----------------------------------------------------------------------------

// Predicts each result word from the input words accepted so far and holds
// the predictions until the block produces them.
class fault_log_scoreboard;

	localparam int DEPTH = 8;

	logic [15:0] ring_slots [DEPTH];
	int oldest_slot;
	int stored_count;
	fhrl_pkg::out_word_t expected_results [$];
	int errors;

	function new();
		foreach (ring_slots[i])
			ring_slots[i] = '0;
		oldest_slot = 0;
		stored_count = 0;
		errors = 0;
	endfunction

	function int pending();
		return expected_results.size();
	endfunction

	// accepted input word: update the shadow ring and queue the result
	function void note_word(fhrl_pkg::in_word_t w);
		fhrl_pkg::out_word_t r;
		int slot;
		r = '0;
		case (w.cmd)
			fhrl_pkg::CMD_LOG: begin
				if (stored_count < DEPTH) begin
					slot = (oldest_slot + stored_count) % DEPTH;
					stored_count++;
				end else begin
					slot = oldest_slot;
					oldest_slot = (oldest_slot + 1) % DEPTH;
				end
				ring_slots[slot] = {w.fault_code, w.fault_arg};
			end
			fhrl_pkg::CMD_READ: begin
				if (int'(w.read_index) < stored_count) begin
					slot = (oldest_slot + int'(w.read_index)) % DEPTH;
					r.entry_code  = ring_slots[slot][15:8];
					r.entry_arg   = ring_slots[slot][7:0];
					r.entry_valid = 1'b1;
				end
			end
			fhrl_pkg::CMD_CLEAR: begin
				stored_count = 0;
				oldest_slot = 0;
			end
			default: ;
		endcase
		r.entry_count = 4'(stored_count);
		expected_results.push_back(r);
	endfunction

	function void check_word(fhrl_pkg::out_word_t got);
		fhrl_pkg::out_word_t want;
		if (expected_results.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: result with nothing expected: code %h arg %h valid %b count %0d",
					$realtime, got.entry_code, got.entry_arg, got.entry_valid,
					got.entry_count);
			return;
		end
		want = expected_results.pop_front();
		if (got.entry_code !== want.entry_code || got.entry_arg !== want.entry_arg ||
				got.entry_valid !== want.entry_valid ||
				got.entry_count !== want.entry_count) begin
			errors++;
			if (errors <= 10)
				$display("%0t: code %h/%h arg %h/%h valid %b/%b count %0d/%0d (exp/act)",
					$realtime, want.entry_code, got.entry_code, want.entry_arg,
					got.entry_arg, want.entry_valid, got.entry_valid,
					want.entry_count, got.entry_count);
		end
	endfunction

	// end of run: anything still queued is a missing result
	function bit all_matched();
		if (expected_results.size() != 0) begin
			errors++;
			$display("%0d result words never arrived", expected_results.size());
		end
		return errors == 0;
	endfunction

endclass

module tb_fault_history_ring_log;
	import fhrl_pkg::*;

	localparam int LOG_DEPTH = 8;
	// the fourth command code has no name in the package; the block ignores it
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 700;
	localparam int LONG_HOLD_CYCLES = 80;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;

	fault_log_scoreboard history_sb = new();

	// quiet: no idling on either side (tail of the run)
	bit quiet = 1'b0;
	// set by the stimulus to make the sink hold off for a long stretch
	bit hold_off_req = 1'b0;

	fault_history_ring_log #(
		.LOG_DEPTH(LOG_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Monitor. Result is checked before the input of the same edge is noted:
	// the result leaving now always belongs to an older word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				history_sb.check_word(out_data);
			if (in_valid && in_ready)
				history_sb.note_word(in_data);
		end
	end

	// Sink. One decision per falling edge, so out_ready gets a single update
	// per step. Random stall bursts, plus the long hold-off
	// on request, which lets the result register and the input side back up.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = LONG_HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic in_word_t make_word(logic [1:0] cmd, logic [7:0] code,
			logic [7:0] arg, logic [7:0] idx);
		in_word_t w;
		w.cmd        = cmd;
		w.fault_code = code;
		w.fault_arg  = arg;
		w.read_index = idx;
		return w;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is
	// taken. A gap lowers valid first, so valid never drops while a word is
	// still on offer.
	task automatic send_word(input in_word_t w);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (history_sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		int gen_fill;
		int pick;
		logic [1:0] cmd;
		logic [7:0] idx;

		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty log, unused code, fill past the depth with
		// extreme values, reads at and beyond the count, clear and refill
		send_word(make_word(CMD_READ, 8'hFF, 8'hFF, 8'd0));      // read on empty
		send_word(make_word(CMD_READ, 8'h00, 8'h00, 8'hFF));
		send_word(make_word(CMD_CLEAR, 8'h00, 8'h00, 8'h00));    // clear on empty
		send_word(make_word(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF));
		send_word(make_word(CMD_LOG, 8'h00, 8'h00, 8'hFF));
		send_word(make_word(CMD_LOG, 8'hFF, 8'hFF, 8'h00));
		send_word(make_word(CMD_LOG, 8'hAA, 8'h55, 8'h00));
		send_word(make_word(CMD_LOG, 8'h55, 8'hAA, 8'h00));
		send_word(make_word(CMD_LOG, 8'h01, 8'h80, 8'h00));
		send_word(make_word(CMD_LOG, 8'h80, 8'h01, 8'h00));
		send_word(make_word(CMD_LOG, 8'h0F, 8'hF0, 8'h00));
		send_word(make_word(CMD_LOG, 8'hF0, 8'h0F, 8'h00));      // now full
		send_word(make_word(CMD_LOG, 8'h12, 8'h34, 8'h00));      // overwrites oldest
		send_word(make_word(CMD_READ, 8'h00, 8'h00, 8'd0));
		send_word(make_word(CMD_READ, 8'h00, 8'h00, 8'd7));
		send_word(make_word(CMD_READ, 8'h00, 8'h00, 8'd8));      // at the count
		send_word(make_word(CMD_READ, 8'h00, 8'h00, 8'hFF));
		send_word(make_word(CMD_UNUSED, 8'h00, 8'h00, 8'd0));    // full, no change
		send_word(make_word(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF));
		send_word(make_word(CMD_READ, 8'h00, 8'h00, 8'd0));      // stale slot, now invalid
		send_word(make_word(CMD_LOG, 8'hC3, 8'h3C, 8'h00));
		send_word(make_word(CMD_READ, 8'h00, 8'h00, 8'd0));
		gen_fill = 1;

		// Random part. Mostly logs and reads near the fill level so the ring
		// wraps often; rare clears and unused codes; random content throughout.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 150)
				hold_off_req = 1'b1;     // long sink stall while words keep coming
			if (n == 350)
				wait_for_drain();
			if (n == RANDOM_WORDS - 100)
				quiet = 1'b1;

			pick = $urandom_range(0, 99);
			if (pick < 44)
				cmd = CMD_LOG;
			else if (pick < 92)
				cmd = CMD_READ;
			else if (pick < 96)
				cmd = CMD_CLEAR;
			else
				cmd = CMD_UNUSED;

			pick = $urandom_range(0, 9);
			if (pick < 7)
				idx = 8'($urandom_range(0, gen_fill));
			else if (pick < 8)
				idx = 8'($urandom_range(LOG_DEPTH, 15));
			else
				idx = 8'($urandom_range(0, 255));

			send_word(make_word(cmd, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), idx));

			// fill level as seen by the generator, only to aim the reads
			if (cmd == CMD_LOG && gen_fill < LOG_DEPTH)
				gen_fill++;
			else if (cmd == CMD_CLEAR)
				gen_fill = 0;
		end

		wait_for_drain();
		repeat (4) @(posedge clk);
		if (history_sb.all_matched())
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
